// ===== sv/psu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PNG scanline unfilter package
// Shared constants, register and filter codes, pipeline item type and the
// Paeth predictor.
// ----------------------------------------------------------------------------
package psu_pkg;

  localparam int MAX_LINE_BYTES = 8192;
  localparam int MAX_BPP        = 8;

  localparam int COL_W      = $clog2(MAX_LINE_BYTES);
  localparam int LEN_W      = $clog2(MAX_LINE_BYTES) + 1;
  localparam int BPP_IDX_W  = $clog2(MAX_BPP);
  localparam int BPP_W      = 4;
  localparam int ROWS_W     = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BPP        = 2'd0,
    REG_LINE_BYTES = 2'd1,
    REG_IMAGE_ROWS = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filt_t;

  typedef struct packed {
    logic [7:0]       x;
    logic [COL_W-1:0] col;
    logic             left_ok;
    logic             up_ok;
    filt_t            filter;
    logic             flagged;
    logic             end_row;
    logic             end_img;
  } item_t;

  function automatic logic [7:0] paeth_pick(logic [7:0] a, logic [7:0] b, logic [7:0] c);
    logic signed [9:0] pa;
    logic signed [9:0] pb;
    logic signed [9:0] pc;
    pa = $signed({2'b00, b}) - $signed({2'b00, c});
    pb = $signed({2'b00, a}) - $signed({2'b00, c});
    pc = pa + pb;
    if (pa < 0) pa = -pa;
    if (pb < 0) pb = -pb;
    if (pc < 0) pc = -pc;
    priority if (pa <= pb && pa <= pc) paeth_pick = a;
    else if (pb <= pc) paeth_pick = b;
    else paeth_pick = c;
  endfunction

endpackage

// ===== sv/png_scanline_unfilter_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PNG scanline unfilter core
// Rebuilds filtered scanline bytes (None, Sub, Up, Average, Paeth) from a
// byte stream with a leading filter type byte per line.
// ----------------------------------------------------------------------------
// Path: a taken data byte is registered in s1_r, then in the output registers.
// Throughput: one byte per cycle while in_stall is low; a filter type byte gives
//   no result. The line store read port is the only memory access per
//   byte, paired with one write from the stage that forms the result.
// Reset: synchronous, active low; clears control state and the histories and
//   loads register defaults. The line store needs no clearing.
module png_scanline_unfilter_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [psu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [psu_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_data_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    out_pixel_byte,
  output logic                          out_last_in_row,
  output logic                          out_last_in_image,
  output logic                          out_bad_filter
);
  import psu_pkg::*;

  logic [BPP_W-1:0]  bpp_r;
  logic [LEN_W-1:0]  line_bytes_r;
  logic [ROWS_W-1:0] image_rows_r;
  logic [BPP_W-1:0]  bpp_c;
  logic [LEN_W-1:0]  len_c;
  logic [ROWS_W-1:0] rows_c;

  logic              expect_type_r, expect_type_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROWS_W-1:0] row_r, row_nxt;
  filt_t             line_filter_r, line_filter_nxt;
  logic              flagged_r, flagged_nxt;

  logic              s1_valid_r, s1_valid_nxt;
  item_t             s1_r, s1_nxt;
  logic [7:0]        up_rd_r;

  logic [7:0]        line_mem [MAX_LINE_BYTES];
  logic [7:0]        left_hist_r [MAX_BPP];
  logic [7:0]        upleft_hist_r [MAX_BPP];

  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_pixel_r;
  logic              out_last_row_r, out_last_img_r, out_bad_r;

  logic              in_acc, data_acc, s1_adv;
  logic              end_row, end_img;
  logic [BPP_W-1:0]  bpp_m1;
  logic [7:0]        a, b, c, pred, pix;
  logic [8:0]        ab_sum;

  // Register clamps
  always_comb begin
    bpp_c = bpp_r;
    if (bpp_r == '0) bpp_c = BPP_W'(1);
    else if (bpp_r > BPP_W'(MAX_BPP)) bpp_c = BPP_W'(MAX_BPP);
    len_c = line_bytes_r;
    if (line_bytes_r == '0) len_c = LEN_W'(1);
    else if (line_bytes_r > LEN_W'(MAX_LINE_BYTES)) len_c = LEN_W'(MAX_LINE_BYTES);
    rows_c = (image_rows_r == '0) ? ROWS_W'(1) : image_rows_r;
  end

  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_acc   = in_valid && !in_stall;
  assign data_acc = in_acc && !expect_type_r;

  assign end_row = ({1'b0, col_r} + LEN_W'(1)) >= len_c;
  assign end_img = end_row && (({1'b0, row_r} + 17'd1) >= {1'b0, rows_c});

  // Line sequencing at the input
  always_comb begin
    expect_type_nxt = expect_type_r;
    col_nxt         = col_r;
    row_nxt         = row_r;
    line_filter_nxt = line_filter_r;
    flagged_nxt     = flagged_r;
    s1_nxt          = s1_r;
    s1_valid_nxt    = s1_valid_r;
    if (s1_adv) s1_valid_nxt = 1'b0;
    if (in_acc) begin
      if (expect_type_r) begin
        if (in_data_byte > 8'd4) begin
          line_filter_nxt = FILT_NONE;
          flagged_nxt     = 1'b1;
        end else begin
          line_filter_nxt = filt_t'(in_data_byte[2:0]);
          flagged_nxt     = 1'b0;
        end
        expect_type_nxt = 1'b0;
        col_nxt         = '0;
      end else begin
        s1_valid_nxt   = 1'b1;
        s1_nxt.x       = in_data_byte;
        s1_nxt.col     = col_r;
        s1_nxt.left_ok = {1'b0, col_r} >= LEN_W'(bpp_c);
        s1_nxt.up_ok   = row_r != '0;
        s1_nxt.filter  = line_filter_r;
        s1_nxt.flagged = flagged_r;
        s1_nxt.end_row = end_row;
        s1_nxt.end_img = end_img;
        if (end_row) begin
          expect_type_nxt = 1'b1;
          col_nxt         = '0;
          row_nxt         = end_img ? '0 : row_r + ROWS_W'(1);
        end else begin
          col_nxt = col_r + COL_W'(1);
        end
      end
    end
  end

  // Reconstruction
  assign bpp_m1 = bpp_c - BPP_W'(1);
  assign a      = s1_r.left_ok ? left_hist_r[bpp_m1[BPP_IDX_W-1:0]] : 8'd0;
  assign b      = s1_r.up_ok ? up_rd_r : 8'd0;
  assign c      = (s1_r.up_ok && s1_r.left_ok) ? upleft_hist_r[bpp_m1[BPP_IDX_W-1:0]] : 8'd0;
  assign ab_sum = {1'b0, a} + {1'b0, b};

  always_comb begin
    unique case (s1_r.filter)
      FILT_SUB:   pred = a;
      FILT_UP:    pred = b;
      FILT_AVG:   pred = ab_sum[8:1];
      FILT_PAETH: pred = paeth_pick(a, b, c);
      default:    pred = 8'd0;
    endcase
  end

  assign pix = s1_r.x + pred;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (s1_adv) out_valid_nxt = 1'b1;
  end

  // Line store
  always_ff @(posedge clk) begin
    if (data_acc) up_rd_r <= line_mem[col_r];
    if (s1_adv) line_mem[s1_r.col] <= pix;
  end

  always_ff @(posedge clk) begin
    s1_r <= s1_nxt;
    if (s1_adv) begin
      out_pixel_r    <= pix;
      out_last_row_r <= s1_r.end_row;
      out_last_img_r <= s1_r.end_img;
      out_bad_r      <= s1_r.flagged;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpp_r         <= BPP_W'(3);
      line_bytes_r  <= LEN_W'(1024);
      image_rows_r  <= ROWS_W'(1);
      expect_type_r <= 1'b1;
      col_r         <= '0;
      row_r         <= '0;
      line_filter_r <= FILT_NONE;
      flagged_r     <= 1'b0;
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      for (int i = 0; i < MAX_BPP; i++) begin
        left_hist_r[i]   <= 8'd0;
        upleft_hist_r[i] <= 8'd0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_BPP:        bpp_r        <= cfg_data[BPP_W-1:0];
          REG_LINE_BYTES: line_bytes_r <= cfg_data[LEN_W-1:0];
          REG_IMAGE_ROWS: image_rows_r <= cfg_data[ROWS_W-1:0];
          default:        ;
        endcase
      end
      expect_type_r <= expect_type_nxt;
      col_r         <= col_nxt;
      row_r         <= row_nxt;
      line_filter_r <= line_filter_nxt;
      flagged_r     <= flagged_nxt;
      s1_valid_r    <= s1_valid_nxt;
      out_valid_r   <= out_valid_nxt;
      if (s1_adv) begin
        left_hist_r[0]   <= pix;
        upleft_hist_r[0] <= b;
        for (int i = 1; i < MAX_BPP; i++) begin
          left_hist_r[i]   <= left_hist_r[i-1];
          upleft_hist_r[i] <= upleft_hist_r[i-1];
        end
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pixel_byte    = out_pixel_r;
  assign out_last_in_row   = out_last_row_r;
  assign out_last_in_image = out_last_img_r;
  assign out_bad_filter    = out_bad_r;

  a_stuck_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && out_stall |-> in_stall)
    else $error("input taken while stage is blocked");

  a_img_end_is_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_img_r |-> out_last_row_r)
    else $error("image end without row end");

  a_row_end_awaits_type: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_r.end_row |-> expect_type_r)
    else $error("row ended but filter type not awaited");

  a_flag_means_none: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_r.flagged |-> s1_r.filter == FILT_NONE)
    else $error("flagged line not rebuilt as None");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PNG scanline unfilter testbench
// Feeds filter type and filtered data bytes through the valid/stall input
// channel and checks every rebuilt pixel byte against a scanline predictor.
// The run starts with a directed table of None, Sub, Up, Average and Paeth
// lines and a bad filter type. A long line with out-of-range register values
// follows, then a line whose length is lowered partway through, then random
// register settings and byte streams. Both sides idle at random, and the
// receiver holds off for long stretches.
// ----------------------------------------------------------------------------
module tb;
  import psu_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 720;
  localparam int LONG_LINE    = 300;
  localparam int DIR_STEPS    = 24;
  localparam int LONG_HOLD    = 400;

  typedef enum {SRC_TABLE, SRC_FORMED, SRC_NOISE} src_mode_t;

  typedef struct {
    logic [7:0] pixel_byte;
    logic       last_in_row;
    logic       last_in_image;
    logic       bad_filter;
  } pixel_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       typed;
    logic       gives;
    logic [7:0] pixel_byte;
    logic       last_in_row;
    logic       last_in_image;
    logic       bad_filter;
  } dir_step_t;

  // two bytes per pixel, three bytes per line, two rows
  dir_step_t dir_table [DIR_STEPS] = '{
    '{8'h00, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{8'h00, 1'b1, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0},
    '{8'hFF, 1'b1, 1'b1, 8'hFF, 1'b0, 1'b0, 1'b0},
    '{8'h80, 1'b1, 1'b1, 8'h80, 1'b1, 1'b0, 1'b0},
    '{8'hFF, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{8'h11, 1'b1, 1'b1, 8'h11, 1'b0, 1'b0, 1'b1},
    '{8'h22, 1'b1, 1'b1, 8'h22, 1'b0, 1'b0, 1'b1},
    '{8'h33, 1'b1, 1'b1, 8'h33, 1'b1, 1'b1, 1'b1},
    '{8'h01, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{8'h10, 1'b1, 1'b1, 8'h10, 1'b0, 1'b0, 1'b0},
    '{8'h20, 1'b1, 1'b1, 8'h20, 1'b0, 1'b0, 1'b0},
    '{8'hF5, 1'b1, 1'b1, 8'h05, 1'b1, 1'b0, 1'b0},
    '{8'h02, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{8'h01, 1'b1, 1'b1, 8'h11, 1'b0, 1'b0, 1'b0},
    '{8'hFF, 1'b1, 1'b1, 8'h1F, 1'b0, 1'b0, 1'b0},
    '{8'h00, 1'b1, 1'b1, 8'h05, 1'b1, 1'b1, 1'b0},
    '{8'h03, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{8'h40, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{8'hC3, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{8'h7E, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{8'h04, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{8'h9A, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{8'h05, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{8'hFE, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0}
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  reg_idx_t              cfg_index = REG_BPP;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [7:0]            in_data_byte = 8'h00;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [7:0]            out_pixel_byte;
  logic                  out_last_in_row;
  logic                  out_last_in_image;
  logic                  out_bad_filter;

  // scanline predictor state
  int unsigned bpp_reg = 3;
  int unsigned len_reg = 1024;
  int unsigned rows_reg = 1;
  logic [7:0]  prev_line [MAX_LINE_BYTES];
  bit          prev_line_valid [MAX_LINE_BYTES];
  logic [7:0]  left_hist [MAX_BPP] = '{default: 8'h00};
  logic [7:0]  upleft_hist [MAX_BPP] = '{default: 8'h00};
  int unsigned col_pos = 0;
  int unsigned row_pos = 0;
  filt_t       line_filt = FILT_NONE;
  bit          line_flagged = 1'b0;
  bit          awaiting_type = 1'b1;

  pixel_t      pending_pixels [$];
  bit          typed_on = 1'b0;
  bit          typed_gives = 1'b0;
  pixel_t      typed_pixel;
  bit          idle_on = 1'b0;
  bit          hold_req = 1'b0;
  int          hold_left = 0;
  int          stall_gap = 0;
  int          cycle_count = 0;
  int          fail_count = 0;
  int          bytes_taken = 0;
  int          pixels_checked = 0;
  int          reg_writes = 0;
  int          filt_lines [5] = '{default: 0};
  int          flagged_lines = 0;

  png_scanline_unfilter_core u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pixel_byte   (out_pixel_byte),
    .out_last_in_row  (out_last_in_row),
    .out_last_in_image(out_last_in_image),
    .out_bad_filter   (out_bad_filter)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [7:0] paeth_choice(input logic [7:0] a, input logic [7:0] b,
                                              input logic [7:0] c);
    int p;
    int da;
    int db;
    int dc;
    p  = int'(a) + int'(b) - int'(c);
    da = p - int'(a);
    db = p - int'(b);
    dc = p - int'(c);
    if (da < 0) da = -da;
    if (db < 0) db = -db;
    if (dc < 0) dc = -dc;
    if (da <= db && da <= dc) return a;
    if (db <= dc) return b;
    return c;
  endfunction

  function automatic int unsigned eff_line_len(input int unsigned raw);
    if (raw < 1) return 1;
    if (raw > MAX_LINE_BYTES) return MAX_LINE_BYTES;
    return raw;
  endfunction

  // Rebuild one stream byte; returns 1 when a pixel byte comes out.
  function automatic bit rebuild_byte(input logic [7:0] x, output pixel_t px);
    int unsigned bpp;
    int unsigned len;
    int unsigned rows;
    int unsigned c_col;
    int          i;
    logic [7:0]  a;
    logic [7:0]  b;
    logic [7:0]  c;
    logic [7:0]  pred;
    logic [8:0]  sum;
    logic [7:0]  pix;
    bit          end_row;
    bit          end_img;
    px = '{8'h00, 1'b0, 1'b0, 1'b0};
    if (awaiting_type) begin
      if (x > 8'd4) begin
        line_filt    = FILT_NONE;
        line_flagged = 1'b1;
        flagged_lines++;
      end else begin
        line_filt    = filt_t'(x[2:0]);
        line_flagged = 1'b0;
        filt_lines[x[2:0]]++;
      end
      awaiting_type = 1'b0;
      col_pos = 0;
      return 1'b0;
    end
    bpp = (bpp_reg < 1) ? 1 : (bpp_reg > MAX_BPP) ? MAX_BPP : bpp_reg;
    len = eff_line_len(len_reg);
    rows = (rows_reg < 1) ? 1 : rows_reg;
    c_col = (col_pos >= MAX_LINE_BYTES) ? MAX_LINE_BYTES - 1 : col_pos;
    a = (c_col >= bpp) ? left_hist[bpp-1] : 8'h00;
    b = (row_pos > 0) ? prev_line[c_col] : 8'h00;
    c = (row_pos > 0 && c_col >= bpp) ? upleft_hist[bpp-1] : 8'h00;
    sum = {1'b0, a} + {1'b0, b};
    case (line_filt)
      FILT_SUB:   pred = a;
      FILT_UP:    pred = b;
      FILT_AVG:   pred = sum[8:1];
      FILT_PAETH: pred = paeth_choice(a, b, c);
      default:    pred = 8'h00;
    endcase
    pix = x + pred;
    prev_line[c_col] = pix;
    prev_line_valid[c_col] = 1'b1;
    for (i = MAX_BPP - 1; i > 0; i--) begin
      left_hist[i]   = left_hist[i-1];
      upleft_hist[i] = upleft_hist[i-1];
    end
    left_hist[0]   = pix;
    upleft_hist[0] = b;
    end_row = (c_col + 1 >= len);
    end_img = end_row && (row_pos + 1 >= rows);
    px = '{pix, end_row, end_img, line_flagged};
    if (end_row) begin
      awaiting_type = 1'b1;
      col_pos = 0;
      row_pos = end_img ? 0 : ((row_pos + 1) & 32'hFFFF);
    end else begin
      col_pos = c_col + 1;
    end
    return 1'b1;
  endfunction

  // A longer line must not read line store entries that were never written.
  function automatic bit line_len_safe(input int unsigned len);
    int unsigned i;
    if (row_pos == 0) return 1'b1;
    for (i = 0; i < len; i++) begin
      if (!prev_line_valid[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [7:0] pick_byte(input src_mode_t mode);
    if (mode == SRC_NOISE) return 8'($urandom_range(0, 255));
    if (awaiting_type) begin
      if ($urandom_range(0, 15) == 0) return 8'($urandom_range(5, 255));
      return 8'($urandom_range(0, 4));
    end
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  always @(posedge clk) begin
    pixel_t px;
    pixel_t want;
    bit     gives;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        bytes_taken++;
        gives = rebuild_byte(in_data_byte, px);
        if (typed_on) begin
          if (typed_gives) pending_pixels.push_back(typed_pixel);
        end else if (gives) begin
          pending_pixels.push_back(px);
        end
      end
      if (out_valid && !out_stall) begin
        stall_gap = idle_on ? $urandom_range(0, 12) : 0;
        if (pending_pixels.size() == 0) begin
          $error("unexpected pixel transaction: pixel_byte %h", out_pixel_byte);
          fail_count++;
        end else begin
          want = pending_pixels.pop_front();
          pixels_checked++;
          if (out_pixel_byte !== want.pixel_byte) begin
            $error("pixel_byte: expected %h, got %h", want.pixel_byte, out_pixel_byte);
            fail_count++;
          end
          if (out_last_in_row !== want.last_in_row) begin
            $error("last_in_row: expected %b, got %b", want.last_in_row, out_last_in_row);
            fail_count++;
          end
          if (out_last_in_image !== want.last_in_image) begin
            $error("last_in_image: expected %b, got %b", want.last_in_image,
                   out_last_in_image);
            fail_count++;
          end
          if (out_bad_filter !== want.bad_filter) begin
            $error("bad_filter: expected %b, got %b", want.bad_filter, out_bad_filter);
            fail_count++;
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_gap > 0) begin
      stall_gap--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_BPP:        bpp_reg = val & 16'h000F;
      REG_LINE_BYTES: len_reg = val & 16'h3FFF;
      REG_IMAGE_ROWS: rows_reg = val;
      default:        ;
    endcase
    reg_writes++;
  endtask

  // Offer one transaction and hold it until it is taken.
  task automatic offer_item(input src_mode_t mode, input dir_step_t step);
    int         gap;
    logic [7:0] b;
    gap = idle_on ? $urandom_range(0, 12) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    if (mode == SRC_TABLE) begin
      b = step.data_byte;
      typed_on = step.typed;
      typed_gives = step.gives;
      typed_pixel = '{step.pixel_byte, step.last_in_row, step.last_in_image,
                      step.bad_filter};
    end else begin
      b = pick_byte(mode);
      typed_on = 1'b0;
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_bytes(input src_mode_t mode, input int n);
    int k;
    for (k = 0; k < n; k++) offer_item(mode, '0);
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic drain_pixels();
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    int          k;
    int          n;
    int          sent;
    int unsigned v;
    src_mode_t   mode;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_reg(REG_BPP, 16'd2);
    write_reg(REG_LINE_BYTES, 16'd3);
    write_reg(REG_IMAGE_ROWS, 16'd2);
    idle_on = 1'b1;
    for (k = 0; k < DIR_STEPS; k++) offer_item(SRC_TABLE, dir_table[k]);
    @(negedge clk);
    in_valid <= 1'b0;
    typed_on = 1'b0;
    drain_pixels();

    // one long line with out-of-range register values, receiver held off
    idle_on = 1'b0;
    write_reg(REG_BPP, 16'd15);
    write_reg(REG_LINE_BYTES, 16'hFFFF);
    write_reg(REG_IMAGE_ROWS, 16'd0);
    hold_req = 1'b1;
    send_bytes(SRC_FORMED, LONG_LINE);
    drain_pixels();

    // shorten the line partway through
    idle_on = 1'b1;
    write_reg(REG_BPP, 16'd0);
    write_reg(REG_LINE_BYTES, 16'd40);
    write_reg(REG_IMAGE_ROWS, 16'd3);
    send_bytes(SRC_FORMED, 21);
    drain_pixels();
    write_reg(REG_LINE_BYTES, 16'd5);
    send_bytes(SRC_FORMED, 30);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      drain_pixels();
      idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 9))
          0:       v = 0;
          1:       v = 15;
          default: v = $urandom_range(1, 8);
        endcase
        write_reg(REG_BPP, 16'(v));
      end
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 11))
          0:       v = 0;
          1:       v = 16'hFFFF;
          default: v = $urandom_range(1, 10);
        endcase
        if (line_len_safe(eff_line_len(v & 16'h3FFF))) write_reg(REG_LINE_BYTES, 16'(v));
      end
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 11))
          0:       v = 0;
          1:       v = 16'hFFFF;
          default: v = $urandom_range(1, 4);
        endcase
        write_reg(REG_IMAGE_ROWS, 16'(v));
      end
      if ($urandom_range(0, 9) == 0) hold_req = 1'b1;
      mode = ($urandom_range(0, 3) == 0) ? SRC_NOISE : SRC_FORMED;
      n = $urandom_range(10, 40);
      send_bytes(mode, n);
      sent += n;
    end
    drain_pixels();
    repeat (8) @(negedge clk);

    $display("Run covered %0d stream bytes, %0d pixel bytes checked, %0d register writes.",
             bytes_taken, pixels_checked, reg_writes);
    $display("Lines by filter: none %0d, sub %0d, up %0d, average %0d, paeth %0d, bad %0d.",
             filt_lines[0], filt_lines[1], filt_lines[2], filt_lines[3], filt_lines[4],
             flagged_lines);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
